// File: rtl/lcg_period_finder_macros.svh
// ----------------------------------------------------------------------------
// lcg period finder assertion macros
// concurrent check wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef LCG_PERIOD_FINDER_MACROS_SVH
`define LCG_PERIOD_FINDER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define LPF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define LPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LPF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define LPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: rtl/lpf_pkg.sv
// ----------------------------------------------------------------------------
// lpf_pkg
// microcode word layout, step names and the control program rom
// ----------------------------------------------------------------------------
package lpf_pkg;

	localparam int PC_W  = 4;
	localparam int LEN_W = 16;

	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [2:0] {
		JC_NONE,
		JC_ALWAYS,
		JC_EQ,
		JC_NE,
		JC_ZMOD
	} jc_t;

	typedef struct packed {
		logic step_en;   // run one generator step through the lcg unit
		logic src_fast;  // unit operand: 1 fast, 0 slow
		logic dst_fast;  // unit result goes to: 1 fast, 0 slow
		logic ld_seed;   // slow and fast take the seed
		logic ld_slow;   // slow alone takes the seed
		logic len_one;   // length counter to one
		logic len_inc;   // length counter up by one, saturating
		logic emit;      // deliver the cycle length
		logic emit_bad;  // deliver the bad modulus result
		jc_t  jc;
		pc_t  target;
	} uword_t;

	// step names
	localparam pc_t ST_LOAD    = 4'd0;
	localparam pc_t ST_P1_SLOW = 4'd1;
	localparam pc_t ST_P1_F1   = 4'd2;
	localparam pc_t ST_P1_F2   = 4'd3;
	localparam pc_t ST_P1_TEST = 4'd4;
	localparam pc_t ST_P2_INIT = 4'd5;
	localparam pc_t ST_P2_TEST = 4'd6;
	localparam pc_t ST_P2_SLOW = 4'd7;
	localparam pc_t ST_P2_FAST = 4'd8;
	localparam pc_t ST_P3_INIT = 4'd9;
	localparam pc_t ST_P3_TEST = 4'd10;
	localparam pc_t ST_P3_STEP = 4'd11;
	localparam pc_t ST_DONE    = 4'd12;
	localparam pc_t ST_BAD     = 4'd13;

	localparam uword_t UW_NOP = '{
		step_en: 1'b0, src_fast: 1'b0, dst_fast: 1'b0, ld_seed: 1'b0,
		ld_slow: 1'b0, len_one: 1'b0, len_inc: 1'b0, emit: 1'b0,
		emit_bad: 1'b0, jc: JC_NONE, target: ST_LOAD
	};

	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		w = UW_NOP;
		case (pc)
			ST_LOAD: begin
				w.ld_seed = 1'b1;
				w.jc      = JC_ZMOD;
				w.target  = ST_BAD;
			end
			ST_P1_SLOW: begin
				w.step_en = 1'b1;
			end
			ST_P1_F1, ST_P1_F2: begin
				w.step_en  = 1'b1;
				w.src_fast = 1'b1;
				w.dst_fast = 1'b1;
			end
			ST_P1_TEST: begin
				w.jc     = JC_NE;
				w.target = ST_P1_SLOW;
			end
			ST_P2_INIT: begin
				w.ld_slow = 1'b1;
			end
			ST_P2_TEST: begin
				w.jc     = JC_EQ;
				w.target = ST_P3_INIT;
			end
			ST_P2_SLOW: begin
				w.step_en = 1'b1;
			end
			ST_P2_FAST: begin
				w.step_en  = 1'b1;
				w.src_fast = 1'b1;
				w.dst_fast = 1'b1;
				w.jc       = JC_ALWAYS;
				w.target   = ST_P2_TEST;
			end
			ST_P3_INIT: begin
				w.step_en  = 1'b1;
				w.src_fast = 1'b1;
				w.dst_fast = 1'b1;
				w.len_one  = 1'b1;
			end
			ST_P3_TEST: begin
				w.jc     = JC_EQ;
				w.target = ST_DONE;
			end
			ST_P3_STEP: begin
				w.step_en  = 1'b1;
				w.src_fast = 1'b1;
				w.dst_fast = 1'b1;
				w.len_inc  = 1'b1;
				w.jc       = JC_ALWAYS;
				w.target   = ST_P3_TEST;
			end
			ST_DONE: begin
				w.emit = 1'b1;
			end
			ST_BAD: begin
				w.emit_bad = 1'b1;
			end
			default: begin
				w.emit_bad = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

// File: rtl/lcg_period_finder.sv
// ----------------------------------------------------------------------------
// lcg_period_finder
// cycle length of a linear congruential generator by tortoise and hare
// ----------------------------------------------------------------------------
// A beat is accepted when start is high and busy is low; multiplier,
// increment, modulus and seed are sampled at that edge and all arithmetic
// runs at VALUE_BITS bits (inputs are truncated or zero extended). The block
// works on one beat at a time and holds busy high until the result is out.
// The result appears for exactly one cycle with done high, together with
// cycle_length and bad_modulus; the receiver cannot stall it, so it must take
// every done beat. A zero modulus returns bad_modulus high and length zero
// through the load step and the bad step. Otherwise the time is set by the
// lcg unit: each generator step runs a multiply, an add, one remainder bit
// per cycle and a retire, and the program needs about 3*(tail+period)
// steps for meeting, 2*tail for the cycle entry and period for the length,
// plus a test word per loop pass. Lengths above 65535 saturate.
// ----------------------------------------------------------------------------
`include "lcg_period_finder_macros.svh"

module lcg_period_finder #(
	parameter int VALUE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] multiplier,
	input  logic [15:0] increment,
	input  logic [15:0] modulus,
	input  logic [15:0] seed,
	output logic        done,
	output logic [15:0] cycle_length,
	output logic        bad_modulus
);
	import lpf_pkg::*;

	// beat acceptance
	logic go;
	assign go = start && !busy;

	// operands held for the whole item
	logic [VALUE_BITS-1:0] mul_q;
	logic [VALUE_BITS-1:0] inc_q;
	logic [VALUE_BITS-1:0] mod_q;
	logic [VALUE_BITS-1:0] seed_q;

	// tortoise, hare and the length counter
	logic [VALUE_BITS-1:0] slow_q;
	logic [VALUE_BITS-1:0] fast_q;
	logic [LEN_W-1:0]      len_q;

	// result beat
	logic             done_q;
	logic [LEN_W-1:0] cycle_length_q;
	logic             bad_modulus_q;

	uword_t                uw;
	logic                  retire;
	logic                  unit_start;
	logic                  unit_done;
	logic [VALUE_BITS-1:0] unit_x;
	logic [VALUE_BITS-1:0] unit_res;
	logic                  vals_eq;
	logic                  mod_zero;

	assign vals_eq  = (slow_q == fast_q);
	assign mod_zero = (mod_q == '0);
	assign unit_x   = uw.src_fast ? fast_q : slow_q;

	lpf_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.unit_done  (unit_done),
		.vals_eq    (vals_eq),
		.mod_zero   (mod_zero),
		.uw         (uw),
		.retire     (retire),
		.unit_start (unit_start),
		.busy       (busy)
	);

	lpf_lcg_unit #(
		.VALUE_BITS (VALUE_BITS)
	) u_lcg (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (unit_start),
		.x       (unit_x),
		.mul     (mul_q),
		.inc     (inc_q),
		.modulus (mod_q),
		.done    (unit_done),
		.result  (unit_res)
	);

	// operand capture, masked to the working width
	always_ff @(posedge clk) begin
		if (go) begin
			mul_q  <= VALUE_BITS'(multiplier);
			inc_q  <= VALUE_BITS'(increment);
			mod_q  <= VALUE_BITS'(modulus);
			seed_q <= VALUE_BITS'(seed);
		end
	end

	// datapath writes happen when a step retires
	always_ff @(posedge clk) begin
		if (retire) begin
			if (uw.ld_seed) begin
				slow_q <= seed_q;
				fast_q <= seed_q;
			end
			if (uw.ld_slow) begin
				slow_q <= seed_q;
			end
			if (uw.step_en) begin
				if (uw.dst_fast) begin
					fast_q <= unit_res;
				end else begin
					slow_q <= unit_res;
				end
			end
			if (uw.len_one) begin
				len_q <= LEN_W'(1);
			end else if (uw.len_inc && (len_q != '1)) begin
				len_q <= len_q + 1'b1;
			end
			if (uw.emit) begin
				cycle_length_q <= len_q;
				bad_modulus_q  <= 1'b0;
			end else if (uw.emit_bad) begin
				cycle_length_q <= '0;
				bad_modulus_q  <= 1'b1;
			end
		end
	end

	// one-cycle result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= retire && (uw.emit || uw.emit_bad);
		end
	end

	assign done         = done_q;
	assign cycle_length = cycle_length_q;
	assign bad_modulus  = bad_modulus_q;

	// result beat leaves with the sequencer already idle
	`LPF_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "result while busy")
	// an accepted beat always starts the sequencer
	`LPF_ASSERT_NEXT(a_go_busy, clk, arst_n, go, busy, "accepted beat did not start")
	// result strobe is a single cycle
	`LPF_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "result strobe held")
	// bad modulus result carries zero length
	`LPF_ASSERT_NOW(a_bad_zero, clk, arst_n, done && bad_modulus, cycle_length == '0,
		"bad modulus with nonzero length")
	// the lcg unit only finishes while a step is pending
	`LPF_ASSERT_NOW(a_unit_owned, clk, arst_n, unit_done, busy && uw.step_en,
		"lcg unit finished outside a step")

endmodule

// File: rtl/lpf_lcg_unit.sv
// ----------------------------------------------------------------------------
// lpf_lcg_unit
// one generator step (mul*x + inc) mod modulus, multiply then restoring divide
// ----------------------------------------------------------------------------
module lpf_lcg_unit #(
	parameter int VALUE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] x,
	input  logic [VALUE_BITS-1:0] mul,
	input  logic [VALUE_BITS-1:0] inc,
	input  logic [VALUE_BITS-1:0] modulus,
	output logic                  done,
	output logic [VALUE_BITS-1:0] result
);
	localparam int PW    = 2 * VALUE_BITS;
	localparam int CNT_W = $clog2(PW);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PW - 1);

	typedef enum logic [1:0] {
		U_IDLE,
		U_ADD,
		U_DIV
	} ustate_t;

	ustate_t               state_q;
	logic [PW-1:0]         prod_q;
	logic [PW-1:0]         dvd_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  done_q;
	logic [VALUE_BITS-1:0] result_q;

	logic [VALUE_BITS:0]   rem_sh;
	logic [VALUE_BITS:0]   rem_sub;
	logic [VALUE_BITS-1:0] rem_next;

	// one quotient bit per cycle
	always_comb begin
		rem_sh  = {rem_q, dvd_q[PW-1]};
		rem_sub = rem_sh - {1'b0, modulus};
		if (rem_sh >= {1'b0, modulus}) begin
			rem_next = rem_sub[VALUE_BITS-1:0];
		end else begin
			rem_next = rem_sh[VALUE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= U_IDLE;
			prod_q   <= '0;
			dvd_q    <= '0;
			rem_q    <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= (state_q == U_DIV) && (cnt_q == CNT_LAST);
			case (state_q)
				U_IDLE: begin
					if (start) begin
						prod_q  <= PW'(mul) * PW'(x);
						state_q <= U_ADD;
					end
				end
				U_ADD: begin
					dvd_q   <= prod_q + PW'(inc);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= U_DIV;
				end
				U_DIV: begin
					rem_q <= rem_next;
					dvd_q <= {dvd_q[PW-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						result_q <= rem_next;
						state_q  <= U_IDLE;
					end
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: rtl/lpf_seq.sv
// ----------------------------------------------------------------------------
// lpf_seq
// step counter over the microcode rom with conditional jumps
// ----------------------------------------------------------------------------
module lpf_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic            unit_done,
	input  logic            vals_eq,
	input  logic            mod_zero,
	output lpf_pkg::uword_t uw,
	output logic            retire,
	output logic            unit_start,
	output logic            busy
);
	import lpf_pkg::*;

	pc_t    pc_q;
	logic   busy_q;
	logic   launched_q;
	logic   take;
	uword_t w;

	assign w = ucode(pc_q);

	always_comb begin
		case (w.jc)
			JC_NONE:   take = 1'b0;
			JC_ALWAYS: take = 1'b1;
			JC_EQ:     take = vals_eq;
			JC_NE:     take = !vals_eq;
			JC_ZMOD:   take = mod_zero;
			default:   take = 1'b0;
		endcase
	end

	assign retire     = busy_q && (!w.step_en || unit_done);
	assign unit_start = busy_q && w.step_en && !launched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= ST_LOAD;
			busy_q     <= 1'b0;
			launched_q <= 1'b0;
		end else begin
			if (!busy_q) begin
				if (go) begin
					busy_q <= 1'b1;
					pc_q   <= ST_LOAD;
				end
			end else begin
				if (unit_start) begin
					launched_q <= 1'b1;
				end
				if (retire) begin
					launched_q <= 1'b0;
					if (w.emit || w.emit_bad) begin
						busy_q <= 1'b0;
						pc_q   <= ST_LOAD;
					end else if (take) begin
						pc_q <= w.target;
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
			end
		end
	end

	assign uw   = w;
	assign busy = busy_q;

endmodule
